// ===== design/mnpt_pkg.sv =====
package mnpt_pkg;

  localparam int unsigned KEY_COUNT = 128;
  localparam int unsigned KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  localparam int unsigned NOTE_W = 7;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON = 4'h9;
  localparam logic [3:0] KIND_CTRL = 4'hB;

  localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCER_ON = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_NOTE = 1'd1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             found;
    logic [KEY_W-1:0] key;
  } scan_status_t;

  function automatic logic [NOTE_W-1:0] note_index(input logic [NOTE_W-1:0] key,
                                                   input logic [NOTE_W-1:0] lowest);
    logic [NOTE_W-1:0] idx;
    if (key < lowest) begin
      idx = '0;
    end else begin
      idx = key - lowest;
    end
    return idx;
  endfunction

endpackage

// ===== design/mnpt_key_map.sv =====
module mnpt_key_map (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [mnpt_pkg::KEY_W-1:0] wr_key_i,
  input  logic                      wr_val_i,
  input  logic                      scan_start_i,
  output mnpt_pkg::scan_status_t    scan_o
);

  logic                           held_mem [mnpt_pkg::KEY_COUNT];
  logic                           clr_q;
  logic [mnpt_pkg::KEY_W-1:0]     clr_idx_q;
  logic                           busy_q;
  logic [mnpt_pkg::KEY_W-1:0]     idx_q;
  logic                           rd_vld_q;
  logic                           rd_bit_q;
  logic [mnpt_pkg::KEY_W-1:0]     rd_key_q;
  logic                           hit;
  logic                           last;
  logic                           idx_last;
  logic                           clr_last;

  assign hit      = rd_vld_q && rd_bit_q;
  assign last     = rd_vld_q && (rd_key_q == mnpt_pkg::KEY_W'(mnpt_pkg::KEY_COUNT - 1));
  assign idx_last = (idx_q == mnpt_pkg::KEY_W'(mnpt_pkg::KEY_COUNT - 1));
  assign clr_last = (clr_idx_q == mnpt_pkg::KEY_W'(mnpt_pkg::KEY_COUNT - 1));

  assign scan_o.busy  = busy_q || clr_q;
  assign scan_o.done  = busy_q && (hit || last);
  assign scan_o.found = hit;
  assign scan_o.key   = rd_key_q;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      held_mem[clr_idx_q] <= 1'b0;
    end else if (wr_en_i) begin
      held_mem[wr_key_i] <= wr_val_i;
    end
    rd_bit_q <= held_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      busy_q    <= 1'b0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_key_q  <= '0;
    end else begin
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_last) begin
          clr_q <= 1'b0;
        end
      end
      if (scan_start_i) begin
        busy_q   <= 1'b1;
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
      end else if (busy_q) begin
        if (hit || last) begin
          busy_q   <= 1'b0;
          rd_vld_q <= 1'b0;
        end else begin
          rd_vld_q <= 1'b1;
          rd_key_q <= idx_q;
          if (!idx_last) begin
            idx_q <= idx_q + 1'b1;
          end
        end
      end
    end
  end

  a_start_clears_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_start_i |=> (busy_q && idx_q == '0 && !rd_vld_q))
    else $error("Scan did not start at the lowest key.");

  a_found_is_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_o.done && scan_o.found) |-> held_mem[rd_key_q])
    else $error("Scan reported a key that is not held.");

  a_scan_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !scan_o.done && !scan_start_i && !idx_last) |=>
      (busy_q && idx_q == $past(idx_q) + 1'b1))
    else $error("Scan index did not advance by one.");

  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_o.busy |-> !wr_en_i)
    else $error("Key map written during a scan or the clearing pass.");

  a_no_scan_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !scan_start_i)
    else $error("Scan started during the clearing pass.");

endmodule

// ===== design/mono_note_priority_tracker.sv =====
// Most messages have their result registered in the cycle after they are accepted.
// Releasing the sounding note while other keys stay held starts a scan of the key map,
// one registered read per cycle from the lowest key; that result is registered when
// the scan hits a held key or reads the last key. Throughput is one transaction per
// cycle without a scan or output stall. Reset clears the held count, sounding note,
// velocity and both registers; a clearing pass empties the key map while input stalls.
module mono_note_priority_tracker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mnpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mnpt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      status_byte_i,
  input  logic [6:0]                      data_one_i,
  input  logic [6:0]                      data_two_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            key_on_o,
  output logic                            key_off_o,
  output logic [6:0]                      current_note_o,
  output logic [6:0]                      velocity_o,
  output logic                            cc_valid_o,
  output logic [6:0]                      cc_number_o,
  output logic [6:0]                      cc_value_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                            state_q;
  logic                              seq_on_q;
  logic [mnpt_pkg::NOTE_W-1:0]       lowest_q;
  logic [mnpt_pkg::COUNT_W-1:0]      count_q;
  logic [mnpt_pkg::NOTE_W-1:0]       sounding_q;
  logic [mnpt_pkg::NOTE_W-1:0]       velocity_q;

  logic                              accept;
  logic [3:0]                        kind;
  logic                              is_on;
  logic                              is_off;
  logic                              is_cc;
  logic [mnpt_pkg::COUNT_W-1:0]      count_dec;
  logic                              matches_sounding;
  logic                              need_scan;
  logic                              in_map;
  logic                              load_result;
  logic [mnpt_pkg::NOTE_W-1:0]       sounding_d;
  logic [mnpt_pkg::COUNT_W-1:0]      count_d;
  logic [mnpt_pkg::NOTE_W-1:0]       velocity_d;
  logic                              key_off_d;
  logic [mnpt_pkg::NOTE_W-1:0]       scan_note;
  mnpt_pkg::scan_status_t            scan;

  assign in_stall_o = (state_q != ST_IDLE) || scan.busy || (out_valid_o && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign kind   = status_byte_i[7:4];
  assign is_on  = !seq_on_q && (kind == mnpt_pkg::KIND_NOTE_ON) && (data_two_i != '0);
  assign is_off = !seq_on_q && ((kind == mnpt_pkg::KIND_NOTE_OFF) ||
                  ((kind == mnpt_pkg::KIND_NOTE_ON) && (data_two_i == '0)));
  assign is_cc  = (kind == mnpt_pkg::KIND_CTRL);
  assign in_map = ({1'b0, data_one_i} < 8'(mnpt_pkg::KEY_COUNT));

  assign count_dec        = (count_q != '0) ? count_q - 1'b1 : '0;
  assign matches_sounding = (data_one_i >= lowest_q) &&
                            ((data_one_i - lowest_q) == sounding_q);
  assign need_scan        = is_off && (count_dec != '0) && matches_sounding;
  assign scan_note        = mnpt_pkg::note_index(7'(scan.key), lowest_q);
  assign load_result      = ((state_q == ST_IDLE) && accept && !need_scan) ||
                            ((state_q == ST_SCAN) && scan.done);

  always_comb begin
    sounding_d = sounding_q;
    count_d    = count_q;
    velocity_d = velocity_q;
    key_off_d  = 1'b0;
    if (!seq_on_q && (kind == mnpt_pkg::KIND_NOTE_ON)) begin
      velocity_d = data_two_i;
    end
    if (is_on) begin
      sounding_d = mnpt_pkg::note_index(data_one_i, lowest_q);
      count_d    = (count_q != mnpt_pkg::COUNT_MAX) ? count_q + 1'b1 : count_q;
    end else if (is_off) begin
      count_d   = count_dec;
      key_off_d = (count_dec == '0);
    end
  end

  mnpt_key_map u_key_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (accept && (is_on || is_off) && in_map),
    .wr_key_i     (mnpt_pkg::KEY_W'(data_one_i)),
    .wr_val_i     (is_on),
    .scan_start_i (accept && need_scan),
    .scan_o       (scan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      seq_on_q       <= 1'b0;
      lowest_q       <= '0;
      count_q        <= '0;
      sounding_q     <= '0;
      velocity_q     <= '0;
      out_valid_o    <= 1'b0;
      key_on_o       <= 1'b0;
      key_off_o      <= 1'b0;
      current_note_o <= '0;
      velocity_o     <= '0;
      cc_valid_o     <= 1'b0;
      cc_number_o    <= '0;
      cc_value_o     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mnpt_pkg::CFG_SEQUENCER_ON: seq_on_q <= cfg_wdata_i[0];
          mnpt_pkg::CFG_LOWEST_NOTE:  lowest_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (load_result) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            count_q    <= count_d;
            sounding_q <= sounding_d;
            velocity_q <= velocity_d;
            if (need_scan) begin
              state_q <= ST_SCAN;
            end else begin
              key_on_o       <= is_on;
              key_off_o      <= key_off_d;
              current_note_o <= sounding_d;
              velocity_o     <= velocity_d;
              cc_valid_o     <= is_cc;
              cc_number_o    <= is_cc ? data_one_i : '0;
              cc_value_o     <= is_cc ? data_two_i : '0;
            end
          end
        end
        ST_SCAN: begin
          if (scan.done) begin
            state_q        <= ST_IDLE;
            key_on_o       <= 1'b0;
            key_off_o      <= 1'b0;
            velocity_o     <= velocity_q;
            cc_valid_o     <= 1'b0;
            cc_number_o    <= '0;
            cc_value_o     <= '0;
            if (scan.found) begin
              sounding_q     <= scan_note;
              current_note_o <= scan_note;
            end else begin
              current_note_o <= sounding_q;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
